@@ rtl/blc_pkg.sv @@
// Shared types, codes and constants for the byte budget LRU cache.
`timescale 1ns / 1ps
package blc_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int TAG_BITS_DEF = 32;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int PIX_W    = 15;
  localparam int PROD_W   = 2 * PIX_W;
  localparam int BYTES_W  = 31;
  localparam int TOTAL_W  = 33;
  localparam int BUDGET_W = 32;
  localparam int EVICT_W  = 7;

  localparam logic [BUDGET_W-1:0] DEFAULT_BUDGET = 32'd314572800;
  localparam logic [BYTES_W-1:0]  BYTES_MAX      = {BYTES_W{1'b1}};
  localparam logic [EVICT_W-1:0]  EVICT_MAX      = {EVICT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_GET      = 2'd0,
    OP_PUT      = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_FIND,
    S_HIT,
    S_DEC,
    S_CHECK,
    S_OLD,
    S_EVICT,
    S_INC,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] handle;
    logic [EVICT_W-1:0]  evicted;
    logic [TOTAL_W-1:0]  bytes;
  } res_t;

endpackage

@@ rtl/blc_ram.sv @@
// Single-port-write, single-port-read entry memory with registered read data.
`timescale 1ns / 1ps
module blc_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 8,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/blc_seq.sv @@
// Operation sequencer: sweeps the entry memory for lookup, rank update and eviction.
`timescale 1ns / 1ps
module blc_seq
  import blc_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                idle,
  input  logic [1:0]          op,
  input  logic [KEY_W-1:0]    key_tag,
  input  logic [HANDLE_W-1:0] data_handle,
  input  logic [PIX_W-1:0]    pixel_width,
  input  logic [PIX_W-1:0]    pixel_height,
  input  logic [BUDGET_W-1:0] budget,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res
);

  localparam int TW  = (TAG_BITS < KEY_W) ? TAG_BITS : KEY_W;
  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int DW  = TW + HANDLE_W + BYTES_W + IW;
  localparam int B_LO = IW;
  localparam int H_LO = IW + BYTES_W;
  localparam int T_LO = IW + BYTES_W + HANDLE_W;

  state_t st_r, st_nxt;

  op_t                 op_r;
  logic [TW-1:0]       tag_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [PIX_W-1:0]    w_r, h_r;
  logic [PROD_W-1:0]   prod_r;
  logic [BYTES_W-1:0]  size;

  logic [ENTRIES-1:0]  valid_r;
  logic [CW-1:0]       count_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [EVICT_W-1:0]  evicted_r;

  logic                hit_r;
  logic [IW-1:0]       s_r;
  logic [IW-1:0]       rank_r;
  logic [HANDLE_W-1:0] hout_r;
  logic [BYTES_W-1:0]  b_r;
  logic                free_ok_r;
  logic [IW-1:0]       free_r;

  // sweep pipeline: read issued at cnt_r, data seen in the next cycle at p_idx_r
  logic [IW:0]         cnt_r;
  logic                p_valid_r;
  logic [IW-1:0]       p_idx_r;
  logic                sweep, issue, sweep_done;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [DW-1:0]       wdata;
  logic [DW-1:0]       rdata;

  logic [TW-1:0]       d_tag;
  logic [HANDLE_W-1:0] d_hdl;
  logic [BYTES_W-1:0]  d_bytes;
  logic [IW-1:0]       d_rank;
  logic                d_v;
  logic                over;

  assign d_rank  = rdata[IW-1:0];
  assign d_bytes = rdata[B_LO +: BYTES_W];
  assign d_hdl   = rdata[H_LO +: HANDLE_W];
  assign d_tag   = rdata[T_LO +: TW];
  assign d_v     = valid_r[p_idx_r];

  assign size = prod_r[PROD_W-1] ? BYTES_MAX : {prod_r[PROD_W-2:0], 2'b00};

  assign over = ({1'b0, total_r} + {3'b000, size}) > {2'b00, budget};

  assign sweep = (st_r == S_FIND) || (st_r == S_DEC) || (st_r == S_OLD) || (st_r == S_INC);
  assign issue = sweep && (cnt_r < (IW+1)'(ENTRIES));
  assign sweep_done = p_valid_r && (p_idx_r == IW'(ENTRIES - 1));

  blc_ram #(.DEPTH(ENTRIES), .DW(DW), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          priority case (op_t'(op))
            OP_GET, OP_CONTAINS: st_nxt = S_FIND;
            OP_PUT:              st_nxt = (data_handle != '0) ? S_SIZE : S_DONE;
            default:             st_nxt = S_DONE;
          endcase
        end
      end
      S_SIZE:  st_nxt = S_FIND;
      S_FIND:  if (sweep_done) st_nxt = S_HIT;
      S_HIT: begin
        if (op_r == OP_PUT)      st_nxt = hit_r ? S_DEC : S_CHECK;
        else if (op_r == OP_GET) st_nxt = hit_r ? S_INC : S_DONE;
        else                     st_nxt = S_DONE;
      end
      S_DEC:   if (sweep_done) st_nxt = S_CHECK;
      S_CHECK: begin
        if (count_r != '0 && (over || count_r >= CW'(ENTRIES))) st_nxt = S_OLD;
        else                                                   st_nxt = S_INC;
      end
      S_OLD:   if (sweep_done) st_nxt = S_EVICT;
      S_EVICT: st_nxt = S_CHECK;
      S_INC:   if (sweep_done) st_nxt = (op_r == OP_PUT) ? S_WRITE : S_DONE;
      S_WRITE: st_nxt = S_DONE;
      S_DONE:  if (res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs: memory write port, handshake and result
  always_comb begin
    we    = 1'b0;
    waddr = p_idx_r;
    wdata = rdata;
    unique case (st_r)
      S_DEC: begin
        if (p_valid_r && d_v && d_rank > rank_r) begin
          we = 1'b1;
          wdata[IW-1:0] = d_rank - IW'(1);
        end
      end
      S_INC: begin
        if (p_valid_r && d_v) begin
          if (op_r == OP_PUT) begin
            we = 1'b1;
            wdata[IW-1:0] = d_rank + IW'(1);
          end else if (p_idx_r == s_r) begin
            we = 1'b1;
            wdata[IW-1:0] = '0;
          end else if (d_rank < rank_r) begin
            we = 1'b1;
            wdata[IW-1:0] = d_rank + IW'(1);
          end
        end
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = free_r;
        wdata = {tag_r, hdl_r, size, {IW{1'b0}}};
      end
      default: ;
    endcase
    idle        = (st_r == S_IDLE);
    res_valid   = (st_r == S_DONE);
    res.found   = hit_r && (op_r == OP_GET || op_r == OP_CONTAINS);
    res.handle  = (hit_r && op_r == OP_GET) ? hout_r : '0;
    res.evicted = (op_r == OP_PUT) ? evicted_r : '0;
    res.bytes   = total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      valid_r   <= '0;
      count_r   <= '0;
      total_r   <= '0;
      cnt_r     <= '0;
      p_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_nxt != st_r) begin
        cnt_r     <= '0;
        p_valid_r <= 1'b0;
      end else if (sweep) begin
        cnt_r     <= issue ? cnt_r + (IW+1)'(1) : cnt_r;
        p_valid_r <= issue;
      end
      unique case (st_r)
        S_IDLE: begin
          if (start && op_t'(op) == OP_CLEAR) begin
            valid_r <= '0;
            count_r <= '0;
            total_r <= '0;
          end
        end
        S_HIT: begin
          if (op_r == OP_PUT && hit_r) begin
            valid_r[s_r] <= 1'b0;
            count_r      <= count_r - CW'(1);
            total_r      <= total_r - {2'b00, b_r};
          end
        end
        S_EVICT: begin
          valid_r[s_r] <= 1'b0;
          count_r      <= count_r - CW'(1);
          total_r      <= total_r - {2'b00, b_r};
        end
        S_WRITE: begin
          valid_r[free_r] <= 1'b1;
          count_r         <= count_r + CW'(1);
          total_r         <= total_r + {2'b00, size};
        end
        default: ;
      endcase
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (sweep) begin
      p_idx_r <= cnt_r[IW-1:0];
    end
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          op_r      <= op_t'(op);
          tag_r     <= key_tag[TW-1:0];
          hdl_r     <= data_handle;
          w_r       <= pixel_width;
          h_r       <= pixel_height;
          hit_r     <= 1'b0;
          evicted_r <= '0;
        end
      end
      S_SIZE: prod_r <= w_r * h_r;
      S_FIND: begin
        if (p_valid_r && d_v && d_tag == tag_r) begin
          hit_r  <= 1'b1;
          s_r    <= p_idx_r;
          rank_r <= d_rank;
          hout_r <= d_hdl;
          b_r    <= d_bytes;
        end
      end
      S_CHECK: free_ok_r <= 1'b0;
      S_OLD: begin
        if (p_valid_r && d_v && {{(CW-IW){1'b0}}, d_rank} == count_r - CW'(1)) begin
          s_r <= p_idx_r;
          b_r <= d_bytes;
        end
      end
      S_EVICT: begin
        if (evicted_r != EVICT_MAX) evicted_r <= evicted_r + EVICT_W'(1);
      end
      S_INC: begin
        if (p_valid_r && !d_v && !free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r    <= p_idx_r;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count disagrees with valid bits");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WRITE |-> (free_ok_r && count_r < CW'(ENTRIES) && !valid_r[free_r]))
    else $error("insert without a free slot");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && !res_ready) |=> st_r == S_DONE)
    else $error("result dropped while stalled");
`endif

endmodule

@@ rtl/byte_budget_lru_cache_top.sv @@
// Top level of the byte budget LRU cache: handshakes, budget register, result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries one operation: get, put, contains
//   or clear, with key tag, handle and image size. One item is worked on at a
//   time; in_ready is high while the sequencer is idle.
//   Result channel (out_valid/out_ready) returns one result per item from an
//   output register, so the next item is taken while a result waits.
//   Config channel (cfg_valid/cfg_ready) writes the byte budget; always ready.
// Each pass over the entry memory issues one read per cycle, with registered
// read data. Clear and a put with a null handle make no pass. Contains makes
// one pass, get one more on a hit, put two plus one per entry evicted and one
// more when the key was present.
// Reset (synchronous, rst_n low) empties the table, zeroes the byte total and
// loads the default budget. No clearing pass is needed: valid bits are flops.
// When out_ready stays low the finished result holds in the output register;
// a following result waits in the sequencer, which then takes no new item.
module byte_budget_lru_cache_top
  import blc_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [KEY_W-1:0]    in_key_tag,
  input  logic [HANDLE_W-1:0] in_data_handle,
  input  logic [PIX_W-1:0]    in_pixel_width,
  input  logic [PIX_W-1:0]    in_pixel_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_found,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [EVICT_W-1:0]  out_evicted_count,
  output logic [TOTAL_W-1:0]  out_bytes_in_use,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_byte_budget
);

  logic [BUDGET_W-1:0] budget_r;
  logic                out_valid_r;
  res_t                out_r;
  logic                seq_idle;
  logic                res_valid, res_ready;
  res_t                res;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle;
  // output register frees up when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  blc_seq #(.ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid && seq_idle),
    .idle         (seq_idle),
    .op           (in_op),
    .key_tag      (in_key_tag),
    .data_handle  (in_data_handle),
    .pixel_width  (in_pixel_width),
    .pixel_height (in_pixel_height),
    .budget       (budget_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= DEFAULT_BUDGET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) budget_r <= cfg_byte_budget;
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_r.found;
  assign out_handle_out    = out_r.handle;
  assign out_evicted_count = out_r.evicted;
  assign out_bytes_in_use  = out_r.bytes;

endmodule

@@ dv/blc_scoreboard.sv @@
// Cache checker: watches the channels, predicts each result and compares it.
`timescale 1ns / 1ps
module blc_scoreboard
  import blc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [KEY_W-1:0]    in_key_tag,
  input  logic [HANDLE_W-1:0] in_data_handle,
  input  logic [PIX_W-1:0]    in_pixel_width,
  input  logic [PIX_W-1:0]    in_pixel_height,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_found,
  input  logic [HANDLE_W-1:0] out_handle_out,
  input  logic [EVICT_W-1:0]  out_evicted_count,
  input  logic [TOTAL_W-1:0]  out_bytes_in_use,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_byte_budget,
  output int                  fail_count,
  output int                  pending
);
  localparam int N = ENTRIES_DEF;

  logic [BUDGET_W-1:0] budget;
  logic                slot_used [N];
  logic [KEY_W-1:0]    slot_tag [N];
  logic [HANDLE_W-1:0] slot_handle [N];
  logic [BYTES_W-1:0]  slot_bytes [N];
  int                  slot_rank [N];
  logic [TOTAL_W-1:0]  held_bytes;
  int                  held_count;
  res_t                want_q [$];

  assign pending = want_q.size();

  function automatic int lookup(logic [KEY_W-1:0] key);
    for (int i = 0; i < N; i++) if (slot_used[i] && slot_tag[i] == key) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < N; i++)
      if (slot_used[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
    slot_used[s] = 1'b0;
    held_bytes = held_bytes - {2'b00, slot_bytes[s]};
    held_count--;
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < N; i++) slot_used[i] = 1'b0;
    held_bytes = '0;
    held_count = 0;
  endfunction

  function automatic res_t cache_op(logic [1:0] op, logic [KEY_W-1:0] key,
                                    logic [HANDLE_W-1:0] hnd, logic [PIX_W-1:0] w,
                                    logic [PIX_W-1:0] h);
    res_t r;
    int s;
    logic [63:0] sz;
    int oldest;
    r = '0;
    case (op_t'(op))
      OP_GET: begin
        s = lookup(key);
        if (s >= 0) begin
          for (int i = 0; i < N; i++)
            if (slot_used[i] && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
          slot_rank[s] = 0;
          r.found = 1'b1;
          r.handle = slot_handle[s];
        end
      end
      OP_CONTAINS: r.found = (lookup(key) >= 0);
      OP_CLEAR: empty_table();
      default: begin
        if (hnd != '0) begin
          sz = 64'(w) * 64'(h) * 64'd4;
          if (sz > 64'(BYTES_MAX)) sz = 64'(BYTES_MAX);
          s = lookup(key);
          if (s >= 0) drop_slot(s);
          while (held_count > 0 &&
                 (64'(held_bytes) + sz > 64'(budget) || held_count >= N)) begin
            oldest = -1;
            for (int i = 0; i < N; i++)
              if (slot_used[i] && slot_rank[i] + 1 == held_count) oldest = i;
            if (oldest < 0) break;
            drop_slot(oldest);
            if (r.evicted != EVICT_MAX) r.evicted++;
          end
          s = -1;
          for (int i = N - 1; i >= 0; i--) if (!slot_used[i]) s = i;
          if (s >= 0) begin
            for (int i = 0; i < N; i++) if (slot_used[i]) slot_rank[i]++;
            slot_used[s] = 1'b1;
            slot_tag[s] = key;
            slot_handle[s] = hnd;
            slot_bytes[s] = sz[BYTES_W-1:0];
            slot_rank[s] = 0;
            held_count++;
            held_bytes = held_bytes + sz[TOTAL_W-1:0];
          end
        end
      end
    endcase
    r.bytes = held_bytes;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      budget <= DEFAULT_BUDGET;
      empty_table();
      want_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (out_found !== want.found ||
              out_handle_out !== want.handle ||
              out_evicted_count !== want.evicted ||
              out_bytes_in_use !== want.bytes) fail_count <= fail_count + 1;
          if (out_found !== want.found)
            $error("found: expected %0d actual %0d", want.found, out_found);
          if (out_handle_out !== want.handle)
            $error("handle_out: expected %0h actual %0h", want.handle, out_handle_out);
          if (out_evicted_count !== want.evicted)
            $error("evicted_count: expected %0d actual %0d", want.evicted,
                   out_evicted_count);
          if (out_bytes_in_use !== want.bytes)
            $error("bytes_in_use: expected %0d actual %0d", want.bytes,
                   out_bytes_in_use);
        end
      end
      if (in_valid && in_ready)
        want_q.push_back(cache_op(in_op, in_key_tag, in_data_handle,
                                  in_pixel_width, in_pixel_height));
      if (cfg_valid && cfg_ready) budget <= cfg_byte_budget;
    end
  end
endmodule

@@ dv/tb_byte_budget_lru_cache_top.sv @@
// Testbench top: drives stimulus into the cache and reports the verdict.
`timescale 1ns / 1ps
module tb_byte_budget_lru_cache_top;
  import blc_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_op = '0;
  logic [KEY_W-1:0]    in_key_tag = '0;
  logic [HANDLE_W-1:0] in_data_handle = '0;
  logic [PIX_W-1:0]    in_pixel_width = '0;
  logic [PIX_W-1:0]    in_pixel_height = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_found;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [EVICT_W-1:0]  out_evicted_count;
  logic [TOTAL_W-1:0]  out_bytes_in_use;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BUDGET_W-1:0] cfg_byte_budget = '0;
  int                  fail_count;
  int                  pending;
  // receiver hold-off request, serviced by the sink process
  bit                  sink_hold = 1'b0;
  bit                  stim_done = 1'b0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  byte_budget_lru_cache_top u_dut (.*);

  blc_scoreboard u_chk (.*);

  // Gap length: mostly short, sometimes long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // One input transfer; valid held until accepted. Valid stays high on return,
  // the caller drops it when it pauses.
  task automatic send_op(op_t op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hnd,
                         logic [PIX_W-1:0] w, logic [PIX_W-1:0] h);
    in_valid <= 1'b1;
    in_op <= op;
    in_key_tag <= key;
    in_data_handle <= hnd;
    in_pixel_width <= w;
    in_pixel_height <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Budget write between phases, only once the cache has drained.
  task automatic set_budget(logic [BUDGET_W-1:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_byte_budget <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random item: small key pool so hits, replaces and evictions are common.
  task automatic rand_item(int key_pool);
    int p;
    int gap;
    logic [KEY_W-1:0] key;
    logic [HANDLE_W-1:0] hnd;
    logic [PIX_W-1:0] w, h;
    p = $urandom_range(0, 99);
    key = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, key_pool);
    hnd = ($urandom_range(0, 19) == 0) ? '0 : $urandom();
    if ($urandom_range(0, 9) == 0) begin
      w = PIX_W'($urandom());
      h = PIX_W'($urandom());
    end else begin
      w = PIX_W'($urandom_range(0, 600));
      h = PIX_W'($urandom_range(0, 600));
    end
    if (p < 45) send_op(OP_PUT, key, hnd, w, h);
    else if (p < 75) send_op(OP_GET, key, hnd, w, h);
    else if (p < 98) send_op(OP_CONTAINS, key, hnd, w, h);
    else send_op(OP_CLEAR, key, hnd, w, h);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        sink_hold = 1'b0;
      end
      gap = pick_gap();
      if (gap == 0 || $urandom_range(0, 1) == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [BUDGET_W-1:0] budgets [5];
    budgets = '{32'h8000_0000, 32'd0, 32'd2000000, 32'hFFFF_FFFF, 32'd314572800};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every op, null handle, replace, zero and oversized size.
    send_op(OP_GET, 32'd5, '0, '0, '0);
    send_op(OP_CONTAINS, 32'hFFFF_FFFF, '0, '0, '0);
    send_op(OP_PUT, 32'd5, 32'hFFFF_FFFF, 15'd100, 15'd100);
    send_op(OP_PUT, 32'd6, '0, 15'd10, 15'd10);
    send_op(OP_PUT, 32'hFFFF_FFFF, 32'd1, 15'd0, 15'd0);
    send_op(OP_CONTAINS, 32'd5, '0, '0, '0);
    send_op(OP_GET, 32'd5, '0, 15'h7FFF, 15'h7FFF);
    send_op(OP_PUT, 32'd5, 32'hA5A5_5A5A, 15'd200, 15'd50);
    send_op(OP_PUT, 32'd7, 32'd3, 15'h7FFF, 15'h7FFF);
    send_op(OP_PUT, 32'd8, 32'd4, 15'd16384, 15'd16384);
    send_op(OP_GET, 32'hFFFF_FFFF, '0, '0, '0);
    send_op(OP_CLEAR, '0, '0, '0, '0);
    send_op(OP_CONTAINS, 32'd8, '0, '0, '0);
    // fill past the table size to force full-table eviction
    for (int i = 0; i < 66; i++) send_op(OP_PUT, 32'(i + 100), 32'(i + 1), 15'd1, 15'd1);
    send_op(OP_GET, 32'd100, '0, '0, '0);
    send_op(OP_GET, 32'd165, '0, '0, '0);

    // Long receiver hold-off while items keep coming.
    sink_hold = 1'b1;
    for (int i = 0; i < 10; i++) rand_item(80);

    // Random phases across budget settings; one pause until fully drained.
    for (int ph = 0; ph < 5; ph++) begin
      set_budget(budgets[ph]);
      for (int i = 0; i < 360; i++) rand_item(ph == 2 ? 30 : 90);
      in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
